>>> design/mdr_pkg.sv
// Package for the motor duty ramp steering block.
// Holds codes, configuration and drive request types and the ramp step function.
// No dependencies; compiled first.
package mdr_pkg;

  localparam int NUM_CH    = 4;
  localparam int CFG_DATA_W = 10;

  // Channel slots in the duty arrays.
  localparam logic [1:0] CH_SORT_A = 2'd0;
  localparam logic [1:0] CH_SORT_B = 2'd1;
  localparam logic [1:0] CH_LEFT   = 2'd2;
  localparam logic [1:0] CH_RIGHT  = 2'd3;

  // Item opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CTL  = 1'b1;

  // Zones.
  localparam logic [2:0] ZONE_STOP_ALL   = 3'd0;
  localparam logic [2:0] ZONE_STOP_DRIVE = 3'd1;
  localparam logic [2:0] ZONE_REDUCED    = 3'd2;
  localparam logic [2:0] ZONE_FULL       = 3'd3;
  localparam logic [2:0] ZONE_SORT       = 3'd4;

  // Direction pin patterns (bit 0 is dir_a, bit 1 is dir_b).
  localparam logic [1:0] DIR_RIGHT = 2'b00;
  localparam logic [1:0] DIR_FWD   = 2'b01;
  localparam logic [1:0] DIR_LEFT  = 2'b11;

  // Register indexes.
  localparam logic [2:0] REG_MAX_FULL     = 3'd0;
  localparam logic [2:0] REG_MAX_REDUCED  = 3'd1;
  localparam logic [2:0] REG_MIN_DUTY     = 3'd2;
  localparam logic [2:0] REG_ERROR_BAND   = 3'd3;
  localparam logic [2:0] REG_STEP_FULL    = 3'd4;
  localparam logic [2:0] REG_STEP_REDUCED = 3'd5;
  localparam logic [2:0] REG_RAMP_DIVIDER = 3'd6;
  localparam logic [2:0] REG_SAFETY_LIMIT = 3'd7;

  // Register reset values.
  localparam logic [7:0] RST_MAX_FULL     = 8'd255;
  localparam logic [7:0] RST_MAX_REDUCED  = 8'd178;
  localparam logic [7:0] RST_MIN_DUTY     = 8'd45;
  localparam logic [6:0] RST_ERROR_BAND   = 7'd15;
  localparam logic [7:0] RST_STEP_FULL    = 8'd14;
  localparam logic [7:0] RST_STEP_REDUCED = 8'd8;
  localparam logic [7:0] RST_RAMP_DIVIDER = 8'd100;
  localparam logic [9:0] RST_SAFETY_LIMIT = 10'd400;

  localparam logic [7:0] SORT_FULL_DUTY = 8'd255;
  localparam logic [9:0] SAFETY_MAX     = 10'd1023;

  typedef struct packed {
    logic [7:0] max_full;
    logic [7:0] max_reduced;
    logic [7:0] min_duty;
    logic [6:0] error_band;
    logic [7:0] step_full;
    logic [7:0] step_reduced;
    logic [7:0] ramp_divider;
    logic [9:0] safety_limit;
  } mdr_cfg_t;

  typedef struct packed {
    logic [1:0] dirs;
    logic [7:0] left;
    logic [7:0] right;
  } mdr_drive_req_t;

  // One ramp step: rise first, then test lowering against the new duty.
  function automatic logic [7:0] ramp_step(input logic [7:0] duty, input logic [7:0] target,
                                           input logic [7:0] min_duty);
    logic [7:0] d;
    d = duty;
    if (target > d) begin
      if (d < min_duty) d = min_duty;
      else d = d + 8'd1;
    end
    if (target < d) begin
      if (d > min_duty) d = d - 8'd1;
      else d = 8'd0;
    end
    return d;
  endfunction

endpackage

>>> design/mdr_ifs.sv
// Valid/ready channel interfaces for the motor duty ramp steering block.
// Depends on nothing; compiled after mdr_pkg.
interface mdr_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [2:0]        zone;
  logic signed [7:0] steer_error;

  modport source (output valid, op, zone, steer_error, input ready);
  modport sink   (input valid, op, zone, steer_error, output ready);
endinterface

interface mdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_sort_a;
  logic [7:0] duty_sort_b;
  logic [7:0] duty_left;
  logic [7:0] duty_right;
  logic       dir_a;
  logic       dir_b;
  logic       sort_enable;
  logic       heartbeat;
  logic       busy_res;

  modport source (output valid, duty_sort_a, duty_sort_b, duty_left, duty_right, dir_a, dir_b,
                  sort_enable, heartbeat, busy_res, input ready);
  modport sink   (input valid, duty_sort_a, duty_sort_b, duty_left, duty_right, dir_a, dir_b,
                  sort_enable, heartbeat, busy_res, output ready);
endinterface

>>> design/motor_duty_ramp_steering.sv
// Top level of the motor duty ramp steering block.
// Depends on mdr_pkg, mdr_ifs (mdr_in_if, mdr_out_if), mdr_cfg and mdr_steer.
//
// Usage:
//   req  - input words: op (tick or control), zone and a signed steering error.
//   rsp  - one result word per input word: the four duties, direction pins,
//          sort enable, heartbeat and busy, all as they stand after that word.
//   cfg_we / cfg_index / cfg_data - register writes, taken on any edge with
//          cfg_we high; write only while the block is idle.
// Pipeline: an input register holds the accepted word; once the result register is
//   free, the word is applied to the motor state and loaded into the result register,
//   which drives rsp; one word per cycle sustained while rsp.ready stays high.
//   The ramp, commit check and steering math all sit between the input
//   register and the state/result registers, with one 8x8 multiply on that path.
// Stall: if rsp.ready is low the result register holds its word, the input
//   register holds one more, and req.ready drops once both are full; nothing
//   is dropped or repeated.
// Reset: rst (synchronous) clears all duties, targets, counters, pins, busy
//   and both pipeline valids, and restores the register defaults.
// Busy: a direction change with both drives running zeroes the drive targets and stays
//   pending (busy_res) until a tick leaves a drive duty at zero; control words are ignored meanwhile.
module motor_duty_ramp_steering
  import mdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mdr_in_if.sink                req,
  mdr_out_if.source             rsp
);

  mdr_cfg_t       cfg;
  mdr_drive_req_t drive;

  // Input register.
  logic              item_valid;
  logic              item_op;
  logic [2:0]        item_zone;
  logic signed [7:0] item_err;

  // Motor state.
  logic [7:0] duty_now [NUM_CH];
  logic [7:0] duty_target [NUM_CH];
  logic [7:0] tick_count;
  logic [9:0] safety_count;
  logic [2:0] current_zone;
  logic [1:0] dir_pins;
  logic       sort_pin;
  logic       beat_level;
  logic       pending_change;
  logic [1:0] pending_dirs;
  logic [7:0] pending_left;
  logic [7:0] pending_right;

  logic [7:0] duty_now_next [NUM_CH];
  logic [7:0] duty_target_next [NUM_CH];
  logic [7:0] tick_count_next;
  logic [9:0] safety_count_next;
  logic [2:0] current_zone_next;
  logic [1:0] dir_pins_next;
  logic       sort_pin_next;
  logic       beat_level_next;
  logic       pending_change_next;
  logic [1:0] pending_dirs_next;
  logic [7:0] pending_left_next;
  logic [7:0] pending_right_next;

  // Result register.
  logic res_valid;

  logic advance;
  logic proc;

  mdr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdr_steer u_steer (
    .cfg         (cfg),
    .full        (item_zone == ZONE_FULL),
    .steer_error (item_err),
    .drive       (drive)
  );

  // Result register frees when empty or taken; input register frees when it moves on.
  assign advance   = !res_valid || rsp.ready;
  assign proc      = item_valid && advance;
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (proc) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_op   <= req.op;
      item_zone <= req.zone;
      item_err  <= req.steer_error;
    end
  end

  // Next motor state for the word in the input register.
  always_comb begin
    duty_now_next       = duty_now;
    duty_target_next    = duty_target;
    tick_count_next     = tick_count;
    safety_count_next   = safety_count;
    current_zone_next   = current_zone;
    dir_pins_next       = dir_pins;
    sort_pin_next       = sort_pin;
    beat_level_next     = beat_level;
    pending_change_next = pending_change;
    pending_dirs_next   = pending_dirs;
    pending_left_next   = pending_left;
    pending_right_next  = pending_right;

    if (item_op == OP_TICK) begin
      if ((current_zone != ZONE_STOP_DRIVE) && (safety_count < SAFETY_MAX)) begin
        safety_count_next = safety_count + 10'd1;
      end
      // Toggle, unless the safety count has run past its limit.
      beat_level_next = beat_level ^ !(safety_count_next > cfg.safety_limit);
      if (tick_count >= cfg.ramp_divider) begin
        for (int i = 0; i < NUM_CH; i++) begin
          duty_now_next[i] = ramp_step(duty_now[i], duty_target[i], cfg.min_duty);
        end
        tick_count_next = 8'd0;
      end else begin
        tick_count_next = tick_count + 8'd1;
      end
      // Commit a waiting direction change once a drive duty sits at zero.
      if (pending_change &&
          ((duty_now_next[CH_LEFT] == 8'd0) || (duty_now_next[CH_RIGHT] == 8'd0))) begin
        dir_pins_next             = pending_dirs;
        duty_target_next[CH_LEFT]  = pending_left;
        duty_target_next[CH_RIGHT] = pending_right;
        pending_change_next       = 1'b0;
      end
    end else if (!pending_change) begin
      current_zone_next = item_zone;
      case (item_zone)
        ZONE_STOP_ALL: begin
          duty_target_next[CH_SORT_A] = 8'd0;
          duty_target_next[CH_SORT_B] = 8'd0;
          duty_target_next[CH_LEFT]   = 8'd0;
          duty_target_next[CH_RIGHT]  = 8'd0;
          sort_pin_next               = 1'b0;
        end
        ZONE_STOP_DRIVE: begin
          duty_target_next[CH_LEFT]  = 8'd0;
          duty_target_next[CH_RIGHT] = 8'd0;
        end
        ZONE_REDUCED, ZONE_FULL: begin
          if (drive.dirs != dir_pins) begin
            pending_dirs_next  = drive.dirs;
            pending_left_next  = drive.left;
            pending_right_next = drive.right;
            if ((duty_now[CH_LEFT] == 8'd0) || (duty_now[CH_RIGHT] == 8'd0)) begin
              // A drive motor already stands still: switch at once.
              dir_pins_next              = drive.dirs;
              duty_target_next[CH_LEFT]  = drive.left;
              duty_target_next[CH_RIGHT] = drive.right;
            end else begin
              duty_target_next[CH_LEFT]  = 8'd0;
              duty_target_next[CH_RIGHT] = 8'd0;
              pending_change_next        = 1'b1;
            end
          end else begin
            duty_target_next[CH_LEFT]  = drive.left;
            duty_target_next[CH_RIGHT] = drive.right;
          end
        end
        ZONE_SORT: begin
          sort_pin_next               = 1'b1;
          duty_target_next[CH_SORT_A] = SORT_FULL_DUTY;
          duty_target_next[CH_SORT_B] = SORT_FULL_DUTY;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        duty_now[i]    <= 8'd0;
        duty_target[i] <= 8'd0;
      end
      tick_count     <= 8'd0;
      safety_count   <= 10'd0;
      current_zone   <= ZONE_STOP_ALL;
      dir_pins       <= DIR_RIGHT;
      sort_pin       <= 1'b0;
      beat_level     <= 1'b0;
      pending_change <= 1'b0;
      pending_dirs   <= DIR_RIGHT;
      pending_left   <= 8'd0;
      pending_right  <= 8'd0;
    end else if (proc) begin
      duty_now       <= duty_now_next;
      duty_target    <= duty_target_next;
      tick_count     <= tick_count_next;
      safety_count   <= safety_count_next;
      current_zone   <= current_zone_next;
      dir_pins       <= dir_pins_next;
      sort_pin       <= sort_pin_next;
      beat_level     <= beat_level_next;
      pending_change <= pending_change_next;
      pending_dirs   <= pending_dirs_next;
      pending_left   <= pending_left_next;
      pending_right  <= pending_right_next;
    end
  end

  // Result register: load the post-word state, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rsp.duty_sort_a <= duty_now_next[CH_SORT_A];
      rsp.duty_sort_b <= duty_now_next[CH_SORT_B];
      rsp.duty_left   <= duty_now_next[CH_LEFT];
      rsp.duty_right  <= duty_now_next[CH_RIGHT];
      rsp.dir_a       <= dir_pins_next[0];
      rsp.dir_b       <= dir_pins_next[1];
      rsp.sort_enable <= sort_pin_next;
      rsp.heartbeat   <= beat_level_next;
      rsp.busy_res    <= pending_change_next;
    end
  end

  assign rsp.valid = res_valid;

  // While a direction change waits, both drive targets stay at zero.
  a_pending_zero_targets: assert property (@(posedge clk) disable iff (rst)
    pending_change |-> (duty_target[CH_LEFT] == 8'd0) && (duty_target[CH_RIGHT] == 8'd0))
    else $error("drive target nonzero while direction change pending");

  // A control word seen while busy leaves the zone untouched.
  a_busy_ignores_ctl: assert property (@(posedge clk) disable iff (rst)
    proc && (item_op == OP_CTL) && pending_change |=> $stable(current_zone))
    else $error("zone changed while busy");

  // Busy clears only with a drive duty at zero.
  a_commit_at_zero: assert property (@(posedge clk) disable iff (rst)
    $fell(pending_change) |-> (duty_now[CH_LEFT] == 8'd0) || (duty_now[CH_RIGHT] == 8'd0))
    else $error("direction committed with both drive duties running");

  // Every processed word leaves a result behind.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    proc |=> res_valid)
    else $error("processed word produced no result");

endmodule

>>> design/mdr_cfg.sv
// Configuration register file for the motor duty ramp steering block.
// Depends on mdr_pkg.
module mdr_cfg
  import mdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output mdr_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_full     <= RST_MAX_FULL;
      cfg.max_reduced  <= RST_MAX_REDUCED;
      cfg.min_duty     <= RST_MIN_DUTY;
      cfg.error_band   <= RST_ERROR_BAND;
      cfg.step_full    <= RST_STEP_FULL;
      cfg.step_reduced <= RST_STEP_REDUCED;
      cfg.ramp_divider <= RST_RAMP_DIVIDER;
      cfg.safety_limit <= RST_SAFETY_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_FULL:     cfg.max_full     <= cfg_data[7:0];
        REG_MAX_REDUCED:  cfg.max_reduced  <= cfg_data[7:0];
        REG_MIN_DUTY:     cfg.min_duty     <= cfg_data[7:0];
        REG_ERROR_BAND:   cfg.error_band   <= cfg_data[6:0];
        REG_STEP_FULL:    cfg.step_full    <= cfg_data[7:0];
        REG_STEP_REDUCED: cfg.step_reduced <= cfg_data[7:0];
        REG_RAMP_DIVIDER: cfg.ramp_divider <= cfg_data[7:0];
        REG_SAFETY_LIMIT: cfg.safety_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/mdr_steer.sv
// Differential steering: turns a zone maximum and a signed error into a drive request.
// Depends on mdr_pkg.
module mdr_steer
  import mdr_pkg::*;
(
  input  mdr_cfg_t          cfg,
  input  logic              full,
  input  logic signed [7:0] steer_error,
  output mdr_drive_req_t    drive
);

  logic [7:0]        maxd;
  logic [7:0]        step;
  logic [7:0]        mag;
  logic [15:0]       prod;
  logic [7:0]        reduced;
  logic signed [8:0] err_w;
  logic signed [8:0] band_w;

  always_comb begin
    maxd   = full ? cfg.max_full : cfg.max_reduced;
    step   = full ? cfg.step_full : cfg.step_reduced;
    err_w  = {steer_error[7], steer_error};
    band_w = {2'b00, cfg.error_band};
    mag    = steer_error[7] ? (~$unsigned(steer_error) + 8'd1) : $unsigned(steer_error);
    prod   = 16'(step) * 16'(mag);
    // Saturate the reduced side at zero.
    reduced = (prod > {8'd0, maxd}) ? 8'd0 : (maxd - prod[7:0]);

    if ((err_w <= band_w) && (err_w >= -band_w)) begin
      drive.dirs  = DIR_FWD;
      drive.left  = steer_error[7] ? maxd : reduced;
      drive.right = steer_error[7] ? reduced : maxd;
    end else if (err_w > band_w) begin
      drive.dirs  = DIR_LEFT;
      drive.left  = cfg.max_full;
      drive.right = cfg.max_full;
    end else begin
      drive.dirs  = DIR_RIGHT;
      drive.left  = cfg.max_full;
      drive.right = cfg.max_full;
    end
  end

endmodule

>>> bench/motor_duty_ramp_steering_tb.sv
// Self-checking bench for motor_duty_ramp_steering: a directed table, then random
// words over several register settings, each result checked against a local model or a table row.
// Depends on mdr_pkg, mdr_in_if, mdr_out_if and motor_duty_ramp_steering from the design folder.
module motor_duty_ramp_steering_tb
  import mdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 250;

  // One result word, field by field, as the block reports it.
  typedef struct packed {
    logic [7:0] sort_a;
    logic [7:0] sort_b;
    logic [7:0] left;
    logic [7:0] right;
    logic       dir_a;
    logic       dir_b;
    logic       sort_en;
    logic       beat;
    logic       busy;
  } motor_status_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic          op;
    logic [2:0]    zone;
    logic [7:0]    err;
    bit            typed;
    motor_status_t want;
  } stim_row_t;

  typedef enum {SET_RANDOM, SET_LOWEST, SET_HIGHEST} setting_kind_t;

  localparam motor_status_t NO_WANT = '0;
  // First tick after reset: only the heartbeat moves.
  localparam motor_status_t WANT_FIRST_TICK =
    '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
  // Sort start: pin up, duties still zero until the next ramp.
  localparam motor_status_t WANT_SORT_ON =
    '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
  // Ramp from zero jumps straight to the default minimum duty.
  localparam motor_status_t WANT_SORT_JUMP =
    '{RST_MIN_DUTY, RST_MIN_DUTY, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  // Directed words, walked with the ramp divider at zero so every tick ramps.
  stim_row_t directed_plan [25] = '{
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b1, WANT_FIRST_TICK},
    '{OP_CTL,  ZONE_SORT,         8'h00, 1'b1, WANT_SORT_ON},
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b1, WANT_SORT_JUMP},
    '{OP_TICK, ZONE_STOP_ALL,     8'hFF, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_FULL,         8'h00, 1'b0, NO_WANT},   // forward, drive at zero
    '{OP_TICK, ZONE_FULL,         8'h7F, 1'b0, NO_WANT},
    '{OP_TICK, ZONE_SORT,         8'h80, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_FULL,         8'd16, 1'b0, NO_WANT},   // turn left, held pending
    '{OP_CTL,  ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},   // ignored while busy
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_REDUCED,      8'h80, 1'b0, NO_WANT},   // turn right
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_SORT + 3'd1,  8'h55, 1'b0, NO_WANT},   // unused zones
    '{OP_CTL,  ZONE_SORT + 3'd3,  8'hAA, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_STOP_DRIVE,   8'h7F, 1'b0, NO_WANT},
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},   // no safety count in stop drive
    '{OP_CTL,  ZONE_REDUCED,      8'd15, 1'b0, NO_WANT},   // upper band edge
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_FULL,         8'hF1, 1'b0, NO_WANT},   // lower band edge
    '{OP_CTL,  ZONE_FULL,         8'h7F, 1'b0, NO_WANT},
    '{OP_CTL,  ZONE_STOP_ALL,     8'hFF, 1'b0, NO_WANT},
    '{OP_TICK, ZONE_STOP_ALL,     8'h00, 1'b0, NO_WANT}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mdr_in_if  req ();
  mdr_out_if rsp ();

  motor_duty_ramp_steering dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  // Model state: the block's registers, duties, counters and pins.
  mdr_cfg_t   cfg_q;
  logic [7:0] duty_q [0:3];
  logic [7:0] aim_q  [0:3];
  logic [7:0] divider_cnt;
  logic [9:0] guard_cnt;
  logic [2:0] zone_q;
  logic [1:0] pins_q;
  logic       sort_q;
  logic       beat_q;
  logic       hold_q;
  logic [1:0] hold_pins;
  logic [7:0] hold_left;
  logic [7:0] hold_right;

  motor_status_t motor_status_q [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a run that hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 13);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic compare_status(input motor_status_t got, input motor_status_t want);
    compare_field("duty_sort_a", got.sort_a, want.sort_a);
    compare_field("duty_sort_b", got.sort_b, want.sort_b);
    compare_field("duty_left", got.left, want.left);
    compare_field("duty_right", got.right, want.right);
    compare_field("dir_a", got.dir_a, want.dir_a);
    compare_field("dir_b", got.dir_b, want.dir_b);
    compare_field("sort_enable", got.sort_en, want.sort_en);
    compare_field("heartbeat", got.beat, want.beat);
    compare_field("busy_res", got.busy, want.busy);
  endtask

  function automatic void clear_model();
    cfg_q = '{RST_MAX_FULL, RST_MAX_REDUCED, RST_MIN_DUTY, RST_ERROR_BAND,
              RST_STEP_FULL, RST_STEP_REDUCED, RST_RAMP_DIVIDER, RST_SAFETY_LIMIT};
    for (int i = 0; i < NUM_CH; i++) begin
      duty_q[i] = '0;
      aim_q[i] = '0;
    end
    divider_cnt = '0;
    guard_cnt = '0;
    zone_q = ZONE_STOP_ALL;
    pins_q = DIR_RIGHT;
    sort_q = 1'b0;
    beat_q = 1'b0;
    hold_q = 1'b0;
    hold_pins = DIR_RIGHT;
    hold_left = '0;
    hold_right = '0;
  endfunction

  // Rise first; the fall test then looks at the risen duty.
  function automatic logic [7:0] nudge_duty(input logic [7:0] d, input logic [7:0] aim);
    logic [7:0] n;
    n = d;
    if (aim > n) n = (n < cfg_q.min_duty) ? cfg_q.min_duty : n + 8'd1;
    if (aim < n) n = (n > cfg_q.min_duty) ? n - 8'd1 : 8'd0;
    return n;
  endfunction

  // Commit a held direction change once either drive duty has reached zero.
  function automatic void settle_dirs();
    if (hold_q && (duty_q[CH_LEFT] == 8'd0 || duty_q[CH_RIGHT] == 8'd0)) begin
      pins_q = hold_pins;
      aim_q[CH_LEFT] = hold_left;
      aim_q[CH_RIGHT] = hold_right;
      hold_q = 1'b0;
    end
  endfunction

  function automatic void ask_drive(input logic [1:0] dirs, input logic [7:0] l,
                                    input logic [7:0] r);
    if (dirs != pins_q) begin
      aim_q[CH_LEFT] = '0;
      aim_q[CH_RIGHT] = '0;
      hold_q = 1'b1;
      hold_pins = dirs;
      hold_left = l;
      hold_right = r;
      settle_dirs();
    end else begin
      aim_q[CH_LEFT] = l;
      aim_q[CH_RIGHT] = r;
    end
  endfunction

  function automatic void steer_drive(input int e, input int maxd, input int step);
    int b;
    int l;
    int r;
    b = cfg_q.error_band;
    l = maxd;
    r = maxd;
    if (e <= b && e >= -b) begin
      if (e >= 0) l = maxd - step * e;
      else r = maxd + step * e;
      if (l < 0) l = 0;
      if (r < 0) r = 0;
      ask_drive(DIR_FWD, l[7:0], r[7:0]);
    end else if (e > b) begin
      ask_drive(DIR_LEFT, cfg_q.max_full, cfg_q.max_full);
    end else begin
      ask_drive(DIR_RIGHT, cfg_q.max_full, cfg_q.max_full);
    end
  endfunction

  // Apply one accepted word to the model and return the status it leaves.
  function automatic motor_status_t advance_motors(input logic op, input logic [2:0] zone,
                                                   input logic [7:0] err_raw);
    motor_status_t st;
    int e;
    e = $signed(err_raw);
    if (op == OP_TICK) begin
      if (zone_q != ZONE_STOP_DRIVE && guard_cnt < SAFETY_MAX) guard_cnt++;
      beat_q = ~beat_q;
      if (divider_cnt >= cfg_q.ramp_divider) begin
        for (int i = 0; i < NUM_CH; i++) duty_q[i] = nudge_duty(duty_q[i], aim_q[i]);
        divider_cnt = '0;
      end else begin
        divider_cnt++;
      end
      if (guard_cnt > cfg_q.safety_limit) beat_q = ~beat_q;
      settle_dirs();
    end else if (!hold_q) begin
      zone_q = zone;
      case (zone)
        ZONE_STOP_ALL: begin
          aim_q[CH_LEFT] = '0;
          aim_q[CH_RIGHT] = '0;
          aim_q[CH_SORT_A] = '0;
          aim_q[CH_SORT_B] = '0;
          sort_q = 1'b0;
        end
        ZONE_STOP_DRIVE: begin
          aim_q[CH_LEFT] = '0;
          aim_q[CH_RIGHT] = '0;
        end
        ZONE_REDUCED: steer_drive(e, cfg_q.max_reduced, cfg_q.step_reduced);
        ZONE_FULL:    steer_drive(e, cfg_q.max_full, cfg_q.step_full);
        ZONE_SORT: begin
          sort_q = 1'b1;
          aim_q[CH_SORT_A] = SORT_FULL_DUTY;
          aim_q[CH_SORT_B] = SORT_FULL_DUTY;
        end
        default: ;
      endcase
    end
    st.sort_a = duty_q[CH_SORT_A];
    st.sort_b = duty_q[CH_SORT_B];
    st.left = duty_q[CH_LEFT];
    st.right = duty_q[CH_RIGHT];
    st.dir_a = pins_q[0];
    st.dir_b = pins_q[1];
    st.sort_en = sort_q;
    st.beat = beat_q;
    st.busy = hold_q;
    return st;
  endfunction

  // Drive one register write and mirror it in the model.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_MAX_FULL:     cfg_q.max_full = val[7:0];
      REG_MAX_REDUCED:  cfg_q.max_reduced = val[7:0];
      REG_MIN_DUTY:     cfg_q.min_duty = val[7:0];
      REG_ERROR_BAND:   cfg_q.error_band = val[6:0];
      REG_STEP_FULL:    cfg_q.step_full = val[7:0];
      REG_STEP_REDUCED: cfg_q.step_reduced = val[7:0];
      REG_RAMP_DIVIDER: cfg_q.ramp_divider = val[7:0];
      REG_SAFETY_LIMIT: cfg_q.safety_limit = val[9:0];
      default: ;
    endcase
  endtask

  // Write every register; random settings keep the divider small so ramps happen.
  task automatic load_settings(input setting_kind_t kind);
    case (kind)
      SET_LOWEST: begin
        write_reg(REG_MAX_FULL, '0);
        write_reg(REG_MAX_REDUCED, '0);
        write_reg(REG_MIN_DUTY, '0);
        write_reg(REG_ERROR_BAND, '0);
        write_reg(REG_STEP_FULL, '0);
        write_reg(REG_STEP_REDUCED, '0);
        write_reg(REG_RAMP_DIVIDER, '0);
        write_reg(REG_SAFETY_LIMIT, '0);
      end
      SET_HIGHEST: begin
        write_reg(REG_MAX_FULL, 10'd255);
        write_reg(REG_MAX_REDUCED, 10'd255);
        write_reg(REG_MIN_DUTY, 10'd255);
        write_reg(REG_ERROR_BAND, 10'd127);
        write_reg(REG_STEP_FULL, 10'd255);
        write_reg(REG_STEP_REDUCED, 10'd255);
        write_reg(REG_RAMP_DIVIDER, 10'd255);
        write_reg(REG_SAFETY_LIMIT, 10'd1023);
      end
      default: begin
        write_reg(REG_MAX_FULL, 10'($urandom_range(0, 255)));
        write_reg(REG_MAX_REDUCED, 10'($urandom_range(0, 255)));
        write_reg(REG_MIN_DUTY, 10'($urandom_range(0, 100)));
        write_reg(REG_ERROR_BAND, 10'($urandom_range(0, 127)));
        write_reg(REG_STEP_FULL, 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, 30)));
        write_reg(REG_STEP_REDUCED, 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                                    : $urandom_range(0, 30)));
        write_reg(REG_RAMP_DIVIDER, 10'($urandom_range(0, 3)));
        write_reg(REG_SAFETY_LIMIT, 10'($urandom_range(0, 1023)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // Offer one word, hold it until accepted, then record what it should produce.
  task automatic push_word(input logic op, input logic [2:0] zone, input logic [7:0] err,
                           input bit use_want, input motor_status_t want);
    motor_status_t st;
    while (idle_roll()) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.zone <= zone;
    req.steer_error <= err;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    st = advance_motors(op, zone, err);
    motor_status_q.push_back(use_want ? want : st);
  endtask

  // Drop valid and hold off until every expected word is back, plus pipeline slack.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (motor_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random words: mostly ticks and steering, with errors both in and out of band.
  task automatic run_random(input int budget, input bit pause_midway);
    int         done;
    bit         paused;
    bit         counts;
    int         r;
    int         band;
    logic       op;
    logic [2:0] zone;
    logic [7:0] err;
    done = 0;
    paused = 1'b0;
    while (done < budget) begin
      if (pause_midway && !paused && done >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      op = ($urandom_range(0, 99) < 62) ? OP_TICK : OP_CTL;
      r = $urandom_range(0, 99);
      if (r < 8)       zone = ZONE_STOP_ALL;
      else if (r < 16) zone = ZONE_STOP_DRIVE;
      else if (r < 46) zone = ZONE_REDUCED;
      else if (r < 76) zone = ZONE_FULL;
      else if (r < 88) zone = ZONE_SORT;
      else             zone = ZONE_SORT + 3'($urandom_range(1, 3));
      band = cfg_q.error_band;
      if ($urandom_range(0, 1) == 0) err = 8'(int'($urandom_range(0, 2 * band)) - band);
      else err = 8'($urandom_range(0, 255));
      // Control words dropped while a change is pending do not advance the phase.
      counts = (op == OP_TICK) || !hold_q;
      push_word(op, zone, err, 1'b0, NO_WANT);
      if (counts) done++;
    end
  endtask

  // Result side: stall at random, unless in the calm stretch.
  always @(posedge clk) rsp.ready <= !idle_roll();

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    motor_status_t got;
    if (rst !== 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got = '{rsp.duty_sort_a, rsp.duty_sort_b, rsp.duty_left, rsp.duty_right, rsp.dir_a,
              rsp.dir_b, rsp.sort_enable, rsp.heartbeat, rsp.busy_res};
      if (motor_status_q.size() == 0) flag_mismatch("result word with nothing expected");
      else compare_status(got, motor_status_q.pop_front());
    end
  end

  setting_kind_t phase_kind [7] = '{SET_RANDOM, SET_LOWEST, SET_RANDOM, SET_HIGHEST,
                                    SET_RANDOM, SET_RANDOM, SET_RANDOM};

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MAX_FULL;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.op <= OP_TICK;
    req.zone <= ZONE_STOP_ALL;
    req.steer_error <= '0;
    clear_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Ramp on every tick so the directed rows see duties move.
    write_reg(REG_RAMP_DIVIDER, '0);
    cfg_we <= 1'b0;
    foreach (directed_plan[i])
      push_word(directed_plan[i].op, directed_plan[i].zone, directed_plan[i].err,
                directed_plan[i].typed, directed_plan[i].want);

    // Advance through the register settings, idle between each.
    foreach (phase_kind[p]) begin
      wait_drained();
      load_settings(phase_kind[p]);
      calm = (p == 4);
      run_random(PHASE_WORDS, p == 2);
      calm = 1'b0;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && motor_status_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
